// File: src/bsr_pkg.sv
// Shared types and constants for the byte stream reassembler.
package bsr_pkg;

  // Field widths fixed by the stream format
  localparam int IDX_W     = 64;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 6;
  localparam int PEND_W    = 6;
  localparam int S_TDATA_W = IDX_W + BYTE_W;
  localparam int M_TDATA_W = 16;

  // Capacity register value after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  // Command codes carried in s_axis_tuser
  localparam logic CMD_MARKER = 1'b1;

  // Classified request as held in the queue between front and back
  typedef struct packed {
    logic              is_data;     // data byte, else end marker
    logic              sets_total;  // marker or final byte: records total length
    logic [IDX_W-1:0]  index;       // stream position of the byte
    logic [IDX_W-1:0]  total;       // total length candidate
    logic [BYTE_W-1:0] data;        // byte value
  } req_t;

endpackage

// File: src/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bsr_front.sv
// Front end: decodes an incoming request and works out the length it records.
module bsr_front (
  input  logic [bsr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output bsr_pkg::req_t                 req
);

  logic [bsr_pkg::IDX_W-1:0] idx;
  logic                      is_marker;

  assign idx       = s_axis_tdata[bsr_pkg::IDX_W-1:0];
  assign is_marker = (s_axis_tuser[0] == bsr_pkg::CMD_MARKER);

  // Marker gives the length directly; a final byte gives its index plus one
  always_comb begin
    req.is_data    = !is_marker;
    req.sets_total = is_marker || s_axis_tlast;
    req.index      = idx;
    req.total      = is_marker ? idx : idx + 64'd1;
    req.data       = s_axis_tdata[bsr_pkg::S_TDATA_W-1:bsr_pkg::IDX_W];
  end

endmodule

// File: src/bsr_fifo.sv
// Two-entry request queue decoupling the front end from the window engine.
module bsr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bsr_pkg::req_t din,
  output logic          full,
  input  logic          pop,
  output bsr_pkg::req_t dout,
  output logic          valid
);

  bsr_pkg::req_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign dout  = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/bsr_back.sv
// Window engine: stores bytes in a circular window, drains the in-order run
// and drives the result register.
module bsr_back #(
  parameter int WINDOW_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsr_pkg::CFG_W-1:0]     cfg_wdata,
  input  bsr_pkg::req_t                 q,
  input  logic                          q_valid,
  output logic                          q_pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bsr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic [0:0]                    m_axis_tuser
);

  localparam int N     = WINDOW_SLOTS;
  localparam int PTR_W = $clog2(N);
  localparam int CNT_W = $clog2(N + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLIP, ST_STORE, ST_SCAN, ST_FIN, ST_NULL, ST_OUT
  } state_t;

  state_t                        state;
  logic [N-1:0]                  filled;
  logic [PTR_W-1:0]              head;
  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W-1:0]              sweep;
  logic [bsr_pkg::IDX_W-1:0]     next_expected;
  logic [bsr_pkg::IDX_W-1:0]     total_length;
  logic                          total_known;
  logic                          closed;
  logic                          dirty;
  logic [bsr_pkg::CFG_W-1:0]     capacity;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              runlen;

  logic                          out_bvalid;
  logic [bsr_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_closed;
  logic [bsr_pkg::PEND_W-1:0]    out_pend;

  logic [CNT_W-1:0]              eff_cap;
  logic [bsr_pkg::IDX_W:0]       diff;
  logic                          in_win;
  logic [PTR_W:0]                phys_sum;
  logic [PTR_W-1:0]              phys;
  logic [PTR_W:0]                sw_diff;
  logic [PTR_W:0]                sw_off;
  logic                          sw_clip;
  logic                          out_free;
  logic                          out_load;
  logic                          ram_re;
  logic [bsr_pkg::BYTE_W-1:0]    ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(N - 1)) ? '0 : p + 1'b1;
  endfunction

  // Capacity clamped to the physical window
  assign eff_cap = (int'(capacity) > N) ? CNT_W'(N) : CNT_W'(capacity);

  // Window hit test and physical slot of the incoming byte
  assign diff     = {1'b0, q.index} - {1'b0, next_expected};
  assign in_win   = q.is_data && !diff[bsr_pkg::IDX_W]
                    && (diff[bsr_pkg::IDX_W-1:CNT_W] == '0)
                    && (diff[CNT_W-1:0] < eff_cap);
  assign phys_sum = {1'b0, head} + {1'b0, diff[PTR_W-1:0]};
  assign phys     = (phys_sum >= (PTR_W+1)'(N)) ? PTR_W'(phys_sum - (PTR_W+1)'(N))
                                                : phys_sum[PTR_W-1:0];

  // Offset of the swept slot from the head, for trimming after a capacity change
  assign sw_diff = {1'b0, sweep} - {1'b0, head};
  assign sw_off  = sw_diff[PTR_W] ? sw_diff + (PTR_W+1)'(N) : sw_diff;
  assign sw_clip = ((CNT_W+1)'(sw_off) >= {1'b0, eff_cap});

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = ((state == ST_NULL) || (state == ST_OUT)) && out_free;
  assign q_pop    = (state == ST_STORE) || (state == ST_IDLE && q_valid && closed);
  assign ram_re   = (state == ST_FIN && runlen != '0)
                    || (state == ST_OUT && out_free && runlen != CNT_W'(1));

  // Result item: out_byte, stream_closed, pending_count from bit 0 up
  assign m_axis_tdata = {1'b0, out_pend, out_closed, out_byte};
  assign m_axis_tuser = out_bvalid;

  bsr_ram #(
    .WIDTH (bsr_pkg::BYTE_W),
    .DEPTH (N)
  ) u_window (
    .clk   (clk),
    .we    (state == ST_STORE && in_win),
    .waddr (phys),
    .wdata (q.data),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      filled        <= '0;
      head          <= '0;
      rd_ptr        <= '0;
      sweep         <= '0;
      next_expected <= '0;
      total_length  <= '0;
      total_known   <= 1'b0;
      closed        <= 1'b0;
      dirty         <= 1'b0;
      capacity      <= bsr_pkg::CAP_RESET;
      count         <= '0;
      runlen        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
        dirty    <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            rd_ptr <= head;
            runlen <= '0;
            if (closed) begin
              state <= ST_FIN;
            end else if (dirty) begin
              sweep <= '0;
              count <= '0;
              state <= ST_CLIP;
            end else begin
              state <= ST_STORE;
            end
          end
        end

        // Drop slots past the new capacity and recount the rest
        ST_CLIP: begin
          if (sw_clip) begin
            filled[sweep] <= 1'b0;
          end else if (filled[sweep]) begin
            count <= count + 1'b1;
          end
          if (sweep == PTR_W'(N - 1)) begin
            dirty <= 1'b0;
            state <= ST_STORE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end

        ST_STORE: begin
          if (q.sets_total) begin
            total_length <= q.total;
            total_known  <= 1'b1;
          end
          if (in_win) begin
            filled[phys] <= 1'b1;
            if (!filled[phys]) begin
              count <= count + 1'b1;
            end
          end
          state <= ST_SCAN;
        end

        // Release the contiguous run at the head, one slot a cycle
        ST_SCAN: begin
          if (filled[head]) begin
            filled[head]  <= 1'b0;
            head          <= ptr_inc(head);
            next_expected <= next_expected + 64'd1;
            runlen        <= runlen + 1'b1;
            count         <= count - 1'b1;
          end else begin
            state <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (total_known && total_length == next_expected) begin
            closed <= 1'b1;
          end
          if (runlen == '0) begin
            state <= ST_NULL;
          end else begin
            rd_ptr <= ptr_inc(rd_ptr);
            state  <= ST_OUT;
          end
        end

        // Empty result when nothing was released
        ST_NULL: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_bvalid    <= 1'b0;
            out_byte      <= '0;
            m_axis_tlast  <= 1'b1;
            out_closed    <= closed;
            out_pend      <= bsr_pkg::PEND_W'(count);
            state         <= ST_IDLE;
          end
        end

        // Stream the released bytes, next read issued alongside each load
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_bvalid    <= 1'b1;
            out_byte      <= ram_rdata;
            m_axis_tlast  <= (runlen == CNT_W'(1));
            out_closed    <= closed;
            out_pend      <= bsr_pkg::PEND_W'(count);
            runlen        <= runlen - 1'b1;
            if (runlen == CNT_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              rd_ptr <= ptr_inc(rd_ptr);
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/byte_stream_reassembler_top.sv
// Byte stream reassembler: top level joining front end, request queue and window engine.
//
// Bytes tagged with their stream position arrive in any order and leave in order. A request
// goes through a two-entry queue to the window engine, which holds WINDOW_SLOTS bytes in a
// circular RAM with one fill flag per slot. The engine stores the byte of a request that falls
// in the window, then the in-order run is found one slot per cycle and read out of the single
// RAM read port one byte per cycle while the output is not stalled; once the stream is
// closed, a request releases nothing. The first request after a capacity write, while the
// stream is open, first runs a trimming pass over the fill flags. Fill flags clear at reset,
// so no clearing pass is needed then. Requests are taken while a result waits downstream.
module byte_stream_reassembler_top #(
  parameter int WINDOW_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bsr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // byte_index, data_byte
  input  logic                          s_axis_tlast,  // ends_stream
  input  logic [0:0]                    s_axis_tuser,  // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bsr_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte, stream_closed, pending_count
  output logic                          m_axis_tlast,  // run_last
  output logic [0:0]                    m_axis_tuser   // byte_valid
);

  bsr_pkg::req_t req_in;
  bsr_pkg::req_t req_head;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;

  assign s_axis_tready = !q_full;

  bsr_front u_front (
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .req          (req_in)
  );

  bsr_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (s_axis_tvalid && !q_full),
    .din   (req_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (req_head),
    .valid (q_valid)
  );

  bsr_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q             (req_head),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: src/bsr_checker.sv
// Port-level checks on the reassembler result stream, bound to the top level.
module bsr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bsr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic [0:0]                    m_axis_tuser
);

  logic closed_seen;

  // Remember that a closed stream has been reported
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_seen <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[8]) begin
      closed_seen <= 1'b1;
    end
  end

  // An empty result carries a zero byte
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("empty result with non-zero byte");

  // An empty result is always the only, hence last, result of its request
  a_null_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty result without last mark");

  // Once closed, the stream stays closed
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && closed_seen |-> m_axis_tdata[8])
    else $error("stream reopened after close");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind byte_stream_reassembler_top bsr_checker u_bsr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
